### rtl/assert_macros.svh
// Assertion macros shared by the checker module of the complex arithmetic unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cau_pkg.sv
// Package of the complex arithmetic unit: widths, action codes, request types.
// Depends on nothing; imported by every module of the unit.
package cau_pkg;

    localparam int CAU_DATA_W     = 32;
    localparam int CAU_FRAC_BITS  = 16;
    localparam int CAU_ACT_W      = 3;
    localparam int CAU_FIFO_DEPTH = 4;

    // Raw action codes as they arrive on the input port.
    localparam logic [CAU_ACT_W-1:0] ACT_ADD  = 3'd0;
    localparam logic [CAU_ACT_W-1:0] ACT_SUB  = 3'd1;
    localparam logic [CAU_ACT_W-1:0] ACT_MUL  = 3'd2;
    localparam logic [CAU_ACT_W-1:0] ACT_DIV  = 3'd3;
    localparam logic [CAU_ACT_W-1:0] ACT_NEG  = 3'd4;
    localparam logic [CAU_ACT_W-1:0] ACT_CONJ = 3'd5;

    // Saturation limits of a result part.
    localparam logic [CAU_DATA_W-1:0] CAU_MAX_POS = {1'b0, {(CAU_DATA_W-1){1'b1}}};
    localparam logic [CAU_DATA_W-1:0] CAU_MAX_NEG = {1'b1, {(CAU_DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_NEG,
        OP_CONJ,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [CAU_ACT_W-1:0]         action;
        logic signed [CAU_DATA_W-1:0] a_re;
        logic signed [CAU_DATA_W-1:0] a_im;
        logic signed [CAU_DATA_W-1:0] b_re;
        logic signed [CAU_DATA_W-1:0] b_im;
    } t_req;

    typedef struct packed {
        logic signed [CAU_DATA_W-1:0] res_re;
        logic signed [CAU_DATA_W-1:0] res_im;
        logic                         div_zero;
        logic                         overflow;
    } t_rsp;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        t_op                          op;
        logic signed [CAU_DATA_W-1:0] a_re;
        logic signed [CAU_DATA_W-1:0] a_im;
        logic signed [CAU_DATA_W-1:0] b_re;
        logic signed [CAU_DATA_W-1:0] b_im;
    } t_cmd;

    // Queue status seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    function automatic t_op cau_decode(input logic [CAU_ACT_W-1:0] act);
        t_op op;
        unique case (act)
            ACT_ADD:  op = OP_ADD;
            ACT_SUB:  op = OP_SUB;
            ACT_MUL:  op = OP_MUL;
            ACT_DIV:  op = OP_DIV;
            ACT_NEG:  op = OP_NEG;
            ACT_CONJ: op = OP_CONJ;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

### rtl/cau_fifo.sv
// Short request queue between the front and back parts of the unit.
// Depends on cau_pkg for the request type.
module cau_fifo
    import cau_pkg::*;
#(
    parameter int DEPTH = CAU_FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_cmd    i_data,
    input  logic    i_rd,
    output t_cmd    o_data,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.valid = (r_cnt != '0);
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && o_stat.valid;
    assign o_data       = r_mem[r_rp];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/cau_front.sv
// Front part: takes requests, classifies the action code and feeds the queue.
// Depends on cau_pkg for the request types and the decoder.
module cau_front
    import cau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_req    i_req,
    output logic    o_full,
    input  t_q_stat i_q_stat,
    output logic    o_q_wr,
    output t_cmd    o_cmd
);

    logic r_v;
    t_cmd r_cmd;
    logic take;

    assign o_q_wr = r_v && !i_q_stat.full;
    assign o_full = r_v && i_q_stat.full;
    assign take   = i_push && !o_full;
    assign o_cmd  = r_cmd;

    // Classified request register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.op   <= cau_decode(i_req.action);
            r_cmd.a_re <= i_req.a_re;
            r_cmd.a_im <= i_req.a_im;
            r_cmd.b_re <= i_req.b_re;
            r_cmd.b_im <= i_req.b_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= 1'b1;
        end else if (o_q_wr) begin
            r_v <= 1'b0;
        end
    end

endmodule

### rtl/cau_back.sv
// Back part: product, sum, restoring divider and saturation pipeline.
// Depends on cau_pkg; the whole pipeline advances together when the output can move.
module cau_back
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_q_stat i_q_stat,
    output logic    o_q_rd,
    output t_rsp    o_rsp,
    output logic    o_empty,
    input  logic    i_pop
);

    localparam int W  = CAU_DATA_W;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = SW + FRAC_BITS;
    localparam int RW = 2 * W + 1;
    localparam int NS = W + 2;

    typedef struct packed {
        t_op                  op;
        logic signed [W-1:0]  a_re, a_im, b_re, b_im;
        logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_bb, p_b2;
    } t_prod;

    typedef struct packed {
        t_op           op;
        logic          neg_re, neg_im;
        logic [NW-1:0] num_re, num_im;
        logic [PW-1:0] den;
        logic [RW-1:0] rem_re, rem_im;
        logic [W-1:0]  q_re, q_im;
        logic          big_re, big_im;
        logic          dz;
    } t_st;

    logic  en;
    t_prod r_p;
    logic  r_p_v;
    t_st   r_st [NS];
    t_st   n_st [NS];
    logic  r_v [NS];
    t_rsp  r_out, n_out;
    logic  r_out_v;

    assign en      = !r_out_v || i_pop;
    assign o_q_rd  = en && i_q_stat.valid;
    assign o_rsp   = r_out;
    assign o_empty = !r_out_v;

    // Products of the operands.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p.op   <= i_cmd.op;
            r_p.a_re <= i_cmd.a_re;
            r_p.a_im <= i_cmd.a_im;
            r_p.b_re <= i_cmd.b_re;
            r_p.b_im <= i_cmd.b_im;
            r_p.p_rr <= $signed(i_cmd.a_re) * $signed(i_cmd.b_re);
            r_p.p_ii <= $signed(i_cmd.a_im) * $signed(i_cmd.b_im);
            r_p.p_ir <= $signed(i_cmd.a_im) * $signed(i_cmd.b_re);
            r_p.p_ri <= $signed(i_cmd.a_re) * $signed(i_cmd.b_im);
            r_p.p_bb <= $signed(i_cmd.b_re) * $signed(i_cmd.b_re);
            r_p.p_b2 <= $signed(i_cmd.b_im) * $signed(i_cmd.b_im);
        end
    end

    // Sums per operation, split into sign and magnitude, then scaled for multiply and divide.
    always_comb begin
        logic signed [SW-1:0] s_re, s_im;
        logic [SW-1:0]        m_re, m_im;
        s_re = '0;
        s_im = '0;
        unique case (r_p.op)
            OP_ADD: begin
                s_re = SW'($signed(r_p.a_re)) + SW'($signed(r_p.b_re));
                s_im = SW'($signed(r_p.a_im)) + SW'($signed(r_p.b_im));
            end
            OP_SUB: begin
                s_re = SW'($signed(r_p.a_re)) - SW'($signed(r_p.b_re));
                s_im = SW'($signed(r_p.a_im)) - SW'($signed(r_p.b_im));
            end
            OP_MUL: begin
                s_re = SW'($signed(r_p.p_rr)) - SW'($signed(r_p.p_ii));
                s_im = SW'($signed(r_p.p_ir)) + SW'($signed(r_p.p_ri));
            end
            OP_DIV: begin
                s_re = SW'($signed(r_p.p_rr)) + SW'($signed(r_p.p_ii));
                s_im = SW'($signed(r_p.p_ir)) - SW'($signed(r_p.p_ri));
            end
            OP_NEG: begin
                s_re = SW'(0) - SW'($signed(r_p.a_re));
                s_im = SW'(0) - SW'($signed(r_p.a_im));
            end
            OP_CONJ: begin
                s_re = SW'($signed(r_p.a_re));
                s_im = SW'(0) - SW'($signed(r_p.a_im));
            end
            default: begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        m_re = s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
        m_im = s_im[SW-1] ? SW'(-s_im) : SW'(s_im);

        n_st[0].op     = r_p.op;
        n_st[0].neg_re = s_re[SW-1];
        n_st[0].neg_im = s_im[SW-1];
        n_st[0].den    = PW'($unsigned(r_p.p_bb)) + PW'($unsigned(r_p.p_b2));
        n_st[0].rem_re = '0;
        n_st[0].rem_im = '0;
        n_st[0].q_re   = '0;
        n_st[0].q_im   = '0;
        n_st[0].big_re = 1'b0;
        n_st[0].big_im = 1'b0;
        n_st[0].dz     = 1'b0;
        if (r_p.op == OP_MUL) begin
            n_st[0].num_re = NW'(m_re >> FRAC_BITS);
            n_st[0].num_im = NW'(m_im >> FRAC_BITS);
        end else if (r_p.op == OP_DIV) begin
            n_st[0].num_re = NW'(m_re) << FRAC_BITS;
            n_st[0].num_im = NW'(m_im) << FRAC_BITS;
        end else begin
            n_st[0].num_re = NW'(m_re);
            n_st[0].num_im = NW'(m_im);
        end
    end

    // Divider set-up: high part of the numerator, quotient range check, zero divisor.
    always_comb begin
        logic [NW-W-1:0] hi_re, hi_im;
        hi_re = r_st[0].num_re[NW-1:W];
        hi_im = r_st[0].num_im[NW-1:W];
        n_st[1]        = r_st[0];
        n_st[1].rem_re = RW'(hi_re);
        n_st[1].rem_im = RW'(hi_im);
        n_st[1].big_re = (NW'(hi_re) >= NW'(r_st[0].den));
        n_st[1].big_im = (NW'(hi_im) >= NW'(r_st[0].den));
        n_st[1].dz     = (r_st[0].op == OP_DIV) && (r_st[0].den == '0);
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < W; k++) begin : g_div
        always_comb begin
            logic [RW-1:0] t_re, t_im;
            t_re = {r_st[k+1].rem_re[RW-2:0], r_st[k+1].num_re[W-1-k]};
            t_im = {r_st[k+1].rem_im[RW-2:0], r_st[k+1].num_im[W-1-k]};
            n_st[k+2] = r_st[k+1];
            if (r_st[k+1].op == OP_DIV) begin
                if (t_re >= RW'(r_st[k+1].den)) begin
                    n_st[k+2].rem_re      = t_re - RW'(r_st[k+1].den);
                    n_st[k+2].q_re[W-1-k] = 1'b1;
                end else begin
                    n_st[k+2].rem_re = t_re;
                end
                if (t_im >= RW'(r_st[k+1].den)) begin
                    n_st[k+2].rem_im      = t_im - RW'(r_st[k+1].den);
                    n_st[k+2].q_im[W-1-k] = 1'b1;
                end else begin
                    n_st[k+2].rem_im = t_im;
                end
            end
        end
    end

    // Narrowing and saturation of both parts.
    always_comb begin
        logic [SW-1:0] mag_re, mag_im, lim_re, lim_im;
        logic          sat_re, sat_im;
        if (r_st[NS-1].op == OP_DIV) begin
            mag_re = SW'(r_st[NS-1].q_re);
            mag_im = SW'(r_st[NS-1].q_im);
            sat_re = r_st[NS-1].big_re;
            sat_im = r_st[NS-1].big_im;
        end else begin
            mag_re = r_st[NS-1].num_re[SW-1:0];
            mag_im = r_st[NS-1].num_im[SW-1:0];
            sat_re = 1'b0;
            sat_im = 1'b0;
        end
        lim_re = r_st[NS-1].neg_re ? SW'(CAU_MAX_NEG) : SW'(CAU_MAX_POS);
        lim_im = r_st[NS-1].neg_im ? SW'(CAU_MAX_NEG) : SW'(CAU_MAX_POS);
        sat_re = sat_re || (mag_re > lim_re);
        sat_im = sat_im || (mag_im > lim_im);
        if (r_st[NS-1].dz) begin
            n_out.res_re   = CAU_MAX_POS;
            n_out.res_im   = CAU_MAX_POS;
            n_out.div_zero = 1'b1;
            n_out.overflow = 1'b0;
        end else begin
            n_out.res_re   = sat_re ? lim_re[W-1:0] :
                             (r_st[NS-1].neg_re ? W'(-mag_re[W-1:0]) : mag_re[W-1:0]);
            n_out.res_im   = sat_im ? lim_im[W-1:0] :
                             (r_st[NS-1].neg_im ? W'(-mag_im[W-1:0]) : mag_im[W-1:0]);
            n_out.div_zero = 1'b0;
            n_out.overflow = sat_re || sat_im;
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                r_st[s] <= n_st[s];
            end
            r_out <= n_out;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v   <= 1'b0;
            r_out_v <= 1'b0;
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_p_v <= i_q_stat.valid;
            r_v[0] <= r_p_v;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_out_v <= r_v[NS-1];
        end
    end

endmodule

### rtl/complex_arithmetic_unit.sv
// Complex fixed-point ALU: add, subtract, multiply, divide, negate, conjugate.
// After the edge that accepts its request, a result passes through the front register, queue,
// products, sums, divider set-up, one divider stage per quotient bit and the output
// register, with the front register loading at the accepting edge.
// Throughput is one request per cycle while full is low; a waiting result stalls the back pipeline.
// Synchronous active-low reset empties the queue and every pipeline stage.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_req i_req,
    output logic full,
    output logic empty,
    input  logic pop,
    output t_rsp o_rsp
);

    t_q_stat q_stat;
    t_cmd    q_in, q_out;
    logic    q_wr, q_rd;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (i_req),
        .o_full   (full),
        .i_q_stat (q_stat),
        .o_q_wr   (q_wr),
        .o_cmd    (q_in)
    );

    cau_fifo #(
        .DEPTH (CAU_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .i_rd    (q_rd),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (q_out),
        .i_q_stat (q_stat),
        .o_q_rd   (q_rd),
        .o_rsp    (o_rsp),
        .o_empty  (empty),
        .i_pop    (pop)
    );

endmodule

### rtl/cau_checker.sv
// Port-level checker of the complex arithmetic unit and its bind statement.
// Depends on cau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cau_checker
    import cau_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic empty,
    input logic pop,
    input t_rsp o_rsp
);

    logic stalled;
    logic dz_ok;
    logic sat_seen;

    // Conditions shared by the assertions below.
    assign stalled  = !empty && !pop;
    assign dz_ok    = !o_rsp.overflow && (o_rsp.res_re == CAU_MAX_POS) &&
                      (o_rsp.res_im == CAU_MAX_POS);
    assign sat_seen = (o_rsp.res_re == CAU_MAX_POS) || (o_rsp.res_re == CAU_MAX_NEG) ||
                      (o_rsp.res_im == CAU_MAX_POS) || (o_rsp.res_im == CAU_MAX_NEG);

    // Reset leaves no result waiting.
    `CAU_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty, "result shown after reset")

    // A waiting result that is not taken stays as it is.
    `CAU_ASSERT(a_hold, i_clk, i_rst_n, stalled |=> !empty && $stable(o_rsp), "held result changed")

    // A zero divisor gives the positive maximum in both parts and no overflow.
    `CAU_ASSERT(a_dz, i_clk, i_rst_n, !empty && o_rsp.div_zero |-> dz_ok, "bad divide-by-zero result")

    // Overflow only comes with a saturated part.
    `CAU_ASSERT(a_ovf, i_clk, i_rst_n, !empty && o_rsp.overflow |-> sat_seen, "overflow without saturation")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_rsp   (o_rsp)
);
